// ===== sv/pa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pa_pkg
// Shared types and codes of the partition allocator.
// ----------------------------------------------------------------------------
package pa_pkg;

  localparam int CMD_W  = 1;
  localparam int ID_W   = 5;
  localparam int SIZE_W = 11;
  localparam int STAT_W = 3;
  localparam int ADDR_W = 10;

  localparam logic [CMD_W-1:0] CMD_FREE  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_ID    = 3'd1;
  localparam logic [STAT_W-1:0] STAT_ZERO_SIZE = 3'd2;
  localparam logic [STAT_W-1:0] STAT_IN_USE    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NO_FIT    = 3'd4;
  localparam logic [STAT_W-1:0] STAT_NOT_ALLOC = 3'd5;
  localparam logic [STAT_W-1:0] STAT_MISMATCH  = 3'd6;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_FR_NX,
    ST_FR_PV,
    ST_PLAN,
    ST_COPY,
    ST_WR_A,
    ST_WR_B,
    ST_DONE
  } state_t;

endpackage : pa_pkg
`default_nettype wire

// ===== sv/pa_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : pa_ram
`default_nettype wire

// ===== sv/partition_allocator_first_best_fit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// partition_allocator_first_best_fit
// Variable-partition allocator over an address-ordered segment table in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Request beat: raise start with in_command / in_job_id / in_req_size while
//   busy is low; the beat is taken at that edge and busy rises.
//   Result beat: out_valid pulses for one cycle with out_status and
//   out_seg_address. The receiver cannot stall; busy drops the cycle after.
//   Config beat: cfg_fit_policy is written when cfg_valid and cfg_ready are
//   high (cfg_ready is always high); write it only while busy is low.
// Sequence:
//   Rejected requests (bad id, zero size, id in use, not allocated) go
//   straight to the result state. Others scan the table one entry per cycle
//   through the single RAM read port, then shift entries one per cycle on
//   split or merge through the copy pipe, then write back one or two
//   entries.
//   busy stays high through the result cycle, so the next request is taken
//   in the cycle after the result at the earliest. One request at a time.
// Reset:
//   rst_n low clears control state; the first cycle after reset writes the
//   initial whole-memory free segment into entry 0 (busy is high meanwhile).
// ----------------------------------------------------------------------------
module partition_allocator_first_best_fit
  import pa_pkg::*;
#(
  parameter int JOB_SLOTS    = 16,
  parameter int MEM_UNITS    = 1024,
  parameter int MAX_SEGMENTS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [CMD_W-1:0]  in_command,
  input  wire logic [ID_W-1:0]   in_job_id,
  input  wire logic [SIZE_W-1:0] in_req_size,
  output logic                   out_valid,
  output logic [STAT_W-1:0]      out_status,
  output logic [ADDR_W-1:0]      out_seg_address,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_fit_policy
);

  localparam int AW = $clog2(MEM_UNITS);
  localparam int LW = $clog2(MEM_UNITS + 1);
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int OW = $clog2(JOB_SLOTS);
  localparam int SW = (LW > SIZE_W) ? LW : SIZE_W;

  typedef struct packed {
    logic [AW-1:0] start;
    logic [LW-1:0] len;
    logic          busy;
    logic [OW-1:0] owner;
  } seg_t;

  localparam int EW = $bits(seg_t);

  state_t state_r, state_nxt;

  logic              fit_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [JOB_SLOTS-1:0] jv_r, jv_nxt;

  // request
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [OW-1:0]     id_r, id_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;

  // scan
  logic [IW-1:0]     eidx_r, eidx_nxt;
  logic              found_r, found_nxt;
  logic [IW-1:0]     pick_r, pick_nxt;
  logic [LW-1:0]     best_len_r, best_len_nxt;
  logic [AW-1:0]     best_start_r, best_start_nxt;

  // free neighbors
  logic [IW-1:0]     fidx_r, fidx_nxt;
  logic [AW-1:0]     fstart_r, fstart_nxt;
  logic [LW-1:0]     flen_r, flen_nxt;
  logic              nfree_r, nfree_nxt;
  logic [LW-1:0]     nlen_r, nlen_nxt;
  logic              pfree_r, pfree_nxt;
  logic [LW-1:0]     plen_r, plen_nxt;
  logic [AW-1:0]     pstart_r, pstart_nxt;

  // shift sequencer
  logic [CW-1:0]     crem_r, crem_nxt;
  logic [IW-1:0]     csrc_r, csrc_nxt;
  logic              cup_r, cup_nxt;
  logic              ck2_r, ck2_nxt;
  logic              pend_r, pend_nxt;
  logic [IW-1:0]     pdst_r, pdst_nxt;

  // final writes
  logic [IW-1:0]     wa_idx_r, wa_idx_nxt;
  seg_t              wa_ent_r, wa_ent_nxt;
  logic              wb_en_r, wb_en_nxt;
  logic [IW-1:0]     wb_idx_r, wb_idx_nxt;
  seg_t              wb_ent_r, wb_ent_nxt;

  // result
  logic [STAT_W-1:0] stat_r, stat_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;

  // RAM port
  logic              ram_we;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  logic [EW-1:0]     ram_wdata, ram_rdata;
  seg_t              rd;

  // shared compare unit
  logic [SW-1:0]     len_ext, size_ext;
  logic              last, fits, take, match, id_bad, jv_hit;

  assign rd       = seg_t'(ram_rdata);
  assign len_ext  = SW'(rd.len);
  assign size_ext = SW'(size_r);
  assign last     = (CW'(eidx_r) + CW'(1)) == cnt_r;
  assign fits     = !rd.busy && ((len_ext == size_ext) ||
                    ((len_ext > size_ext) && (cnt_r < CW'(MAX_SEGMENTS))));
  assign take     = fits && (!found_r || (fit_r && (rd.len < best_len_r)));
  assign match    = rd.busy && (rd.owner == id_r);
  assign id_bad   = (in_job_id == '0) || (32'(in_job_id) >= JOB_SLOTS);
  assign jv_hit   = !id_bad && jv_r[in_job_id[OW-1:0]];

  pa_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_SEGMENTS)
  ) u_seg_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // config register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      fit_r <= cfg_fit_policy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      cnt_r   <= CW'(1);
      jv_r    <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      jv_r    <= jv_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    id_r         <= id_nxt;
    size_r       <= size_nxt;
    eidx_r       <= eidx_nxt;
    found_r      <= found_nxt;
    pick_r       <= pick_nxt;
    best_len_r   <= best_len_nxt;
    best_start_r <= best_start_nxt;
    fidx_r       <= fidx_nxt;
    fstart_r     <= fstart_nxt;
    flen_r       <= flen_nxt;
    nfree_r      <= nfree_nxt;
    nlen_r       <= nlen_nxt;
    pfree_r      <= pfree_nxt;
    plen_r       <= plen_nxt;
    pstart_r     <= pstart_nxt;
    crem_r       <= crem_nxt;
    csrc_r       <= csrc_nxt;
    cup_r        <= cup_nxt;
    ck2_r        <= ck2_nxt;
    pdst_r       <= pdst_nxt;
    wa_idx_r     <= wa_idx_nxt;
    wa_ent_r     <= wa_ent_nxt;
    wb_en_r      <= wb_en_nxt;
    wb_idx_r     <= wb_idx_nxt;
    wb_ent_r     <= wb_ent_nxt;
    stat_r       <= stat_nxt;
    addr_r       <= addr_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    jv_nxt         = jv_r;
    cmd_nxt        = cmd_r;
    id_nxt         = id_r;
    size_nxt       = size_r;
    eidx_nxt       = eidx_r;
    found_nxt      = found_r;
    pick_nxt       = pick_r;
    best_len_nxt   = best_len_r;
    best_start_nxt = best_start_r;
    fidx_nxt       = fidx_r;
    fstart_nxt     = fstart_r;
    flen_nxt       = flen_r;
    nfree_nxt      = nfree_r;
    nlen_nxt       = nlen_r;
    pfree_nxt      = pfree_r;
    plen_nxt       = plen_r;
    pstart_nxt     = pstart_r;
    crem_nxt       = crem_r;
    csrc_nxt       = csrc_r;
    cup_nxt        = cup_r;
    ck2_nxt        = ck2_r;
    pend_nxt       = pend_r;
    pdst_nxt       = pdst_r;
    wa_idx_nxt     = wa_idx_r;
    wa_ent_nxt     = wa_ent_r;
    wb_en_nxt      = wb_en_r;
    wb_idx_nxt     = wb_idx_r;
    wb_ent_nxt     = wb_ent_r;
    stat_nxt       = stat_r;
    addr_nxt       = addr_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_raddr      = eidx_r + IW'(1);

    unique case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = seg_t'{start: '0, len: LW'(MEM_UNITS), busy: 1'b0, owner: '0};
        state_nxt = ST_IDLE;
      end

      ST_IDLE: begin
        if (start) begin
          cmd_nxt   = in_command;
          id_nxt    = in_job_id[OW-1:0];
          size_nxt  = in_req_size;
          addr_nxt  = '0;
          eidx_nxt  = '0;
          found_nxt = 1'b0;
          ram_raddr = '0;
          state_nxt = ST_DONE;
          if (id_bad) begin
            stat_nxt = STAT_BAD_ID;
          end else if (in_req_size == '0) begin
            stat_nxt = STAT_ZERO_SIZE;
          end else if ((in_command == CMD_ALLOC) && jv_hit) begin
            stat_nxt = STAT_IN_USE;
          end else if ((in_command == CMD_FREE) && !jv_hit) begin
            stat_nxt = STAT_NOT_ALLOC;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        eidx_nxt = eidx_r + IW'(1);
        if (cmd_r == CMD_ALLOC) begin
          if (take) begin
            pick_nxt       = eidx_r;
            best_len_nxt   = rd.len;
            best_start_nxt = rd.start;
            found_nxt      = 1'b1;
          end
          if ((take && !fit_r) || last) begin
            if (found_r || take) begin
              state_nxt = ST_PLAN;
            end else begin
              stat_nxt  = STAT_NO_FIT;
              state_nxt = ST_DONE;
            end
          end
        end else begin
          if (match) begin
            fidx_nxt   = eidx_r;
            fstart_nxt = rd.start;
            flen_nxt   = rd.len;
            if (len_ext != size_ext) begin
              stat_nxt  = STAT_MISMATCH;
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_FR_NX;  // read of entry+1 already issued
            end
          end else if (last) begin
            stat_nxt  = STAT_NOT_ALLOC;  // valid bit set but segment lost
            state_nxt = ST_DONE;
          end
        end
      end

      ST_FR_NX: begin
        nfree_nxt = ((CW'(fidx_r) + CW'(1)) < cnt_r) && !rd.busy;
        nlen_nxt  = rd.len;
        ram_raddr = fidx_r - IW'(1);
        state_nxt = ST_FR_PV;
      end

      ST_FR_PV: begin
        pfree_nxt  = (fidx_r != '0) && !rd.busy;
        plen_nxt   = rd.len;
        pstart_nxt = rd.start;
        state_nxt  = ST_PLAN;
      end

      ST_PLAN: begin
        stat_nxt  = STAT_OK;
        pend_nxt  = 1'b0;
        wb_en_nxt = 1'b0;
        state_nxt = ST_COPY;
        if (cmd_r == CMD_ALLOC) begin
          jv_nxt[id_r] = 1'b1;
          addr_nxt     = ADDR_W'(best_start_r);
          wa_idx_nxt   = pick_r;
          wa_ent_nxt   = seg_t'{start: best_start_r, len: LW'(size_r),
                                busy: 1'b1, owner: id_r};
          cup_nxt      = 1'b1;
          ck2_nxt      = 1'b0;
          crem_nxt     = '0;
          if (SW'(best_len_r) > size_ext) begin
            // split: open a slot after the pick
            cnt_nxt    = cnt_r + CW'(1);
            crem_nxt   = cnt_r - CW'(1) - CW'(pick_r);
            csrc_nxt   = IW'(cnt_r - CW'(1));
            wb_en_nxt  = 1'b1;
            wb_idx_nxt = pick_r + IW'(1);
            wb_ent_nxt = seg_t'{start: AW'(best_start_r + AW'(size_r)),
                                len: LW'(best_len_r - LW'(size_r)),
                                busy: 1'b0, owner: '0};
          end
        end else begin
          jv_nxt[id_r] = 1'b0;
          addr_nxt     = ADDR_W'(fstart_r);
          cup_nxt      = 1'b0;
          ck2_nxt      = 1'b0;
          crem_nxt     = '0;
          if (nfree_r && pfree_r) begin
            ck2_nxt    = 1'b1;
            cnt_nxt    = cnt_r - CW'(2);
            crem_nxt   = cnt_r - CW'(fidx_r) - CW'(2);
            csrc_nxt   = fidx_r + IW'(2);
            wa_idx_nxt = fidx_r - IW'(1);
            wa_ent_nxt = seg_t'{start: pstart_r, len: LW'(plen_r + flen_r + nlen_r),
                                busy: 1'b0, owner: '0};
          end else if (nfree_r) begin
            cnt_nxt    = cnt_r - CW'(1);
            crem_nxt   = cnt_r - CW'(fidx_r) - CW'(2);
            csrc_nxt   = fidx_r + IW'(2);
            wa_idx_nxt = fidx_r;
            wa_ent_nxt = seg_t'{start: fstart_r, len: LW'(flen_r + nlen_r),
                                busy: 1'b0, owner: '0};
          end else if (pfree_r) begin
            cnt_nxt    = cnt_r - CW'(1);
            crem_nxt   = cnt_r - CW'(fidx_r) - CW'(1);
            csrc_nxt   = fidx_r + IW'(1);
            wa_idx_nxt = fidx_r - IW'(1);
            wa_ent_nxt = seg_t'{start: pstart_r, len: LW'(plen_r + flen_r),
                                busy: 1'b0, owner: '0};
          end else begin
            wa_idx_nxt = fidx_r;
            wa_ent_nxt = seg_t'{start: fstart_r, len: flen_r, busy: 1'b0, owner: '0};
          end
        end
      end

      ST_COPY: begin
        // read one entry per cycle, write it at its new slot the next cycle
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = pdst_r;
          ram_wdata = ram_rdata;
        end
        if (crem_r != '0) begin
          ram_raddr = csrc_r;
          crem_nxt  = crem_r - CW'(1);
          csrc_nxt  = cup_r ? (csrc_r - IW'(1)) : (csrc_r + IW'(1));
          pdst_nxt  = cup_r ? (csrc_r + IW'(1))
                            : (csrc_r - (ck2_r ? IW'(2) : IW'(1)));
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = ST_WR_A;
          end
        end
      end

      ST_WR_A: begin
        ram_we    = 1'b1;
        ram_waddr = wa_idx_r;
        ram_wdata = wa_ent_r;
        state_nxt = wb_en_r ? ST_WR_B : ST_DONE;
      end

      ST_WR_B: begin
        ram_we    = 1'b1;
        ram_waddr = wb_idx_r;
        ram_wdata = wb_ent_r;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = (state_r == ST_DONE);
  assign out_status      = stat_r;
  assign out_seg_address = addr_r;

  // the table always holds at least one segment and never overflows
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) && (cnt_r <= CW'(MAX_SEGMENTS)))
    else $error("segment count out of range");

  // an accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request beat did not raise busy");

  // any failed request reports address zero
  a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STAT_OK)) |-> (out_seg_address == '0))
    else $error("nonzero address on failure");

  // a result beat is followed by idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("no idle after result beat");

  // table writes only happen off the idle state
  a_we_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> busy)
    else $error("table write while idle");

endmodule : partition_allocator_first_best_fit
`default_nettype wire
